/* rtl/core/morse_char_to_pulses_top_defines.svh */
// Assertion macros used by the Morse encoder RTL.
`ifndef MORSE_CHAR_TO_PULSES_TOP_DEFINES_SVH
`define MORSE_CHAR_TO_PULSES_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define MCP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define MCP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mcp_pkg.sv */
// Package: types, constants and pattern table of the Morse encoder.
`default_nettype none

package mcp_pkg;

  localparam int MAX_SYMBOLS = 7;
  localparam int PAT_W       = 7;
  localparam int LEN_W       = $clog2(MAX_SYMBOLS + 1);
  localparam int UNIT_W      = 16;
  localparam int DUR_W       = 18;
  localparam int CODE_W      = 8;

  localparam logic [UNIT_W-1:0] UNIT_RESET = UNIT_W'(300);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_e;

  // Pattern entry: symbol count (0 = unmapped) and left-aligned symbols,
  // first symbol in the top bit, 1 = dah.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [PAT_W-1:0] dah;
  } entry_t;

  function automatic entry_t mk_entry(input int n, input logic [PAT_W-1:0] bits);
    entry_t e;
    int     m;
    m     = (n > MAX_SYMBOLS) ? MAX_SYMBOLS : n;
    e.len = LEN_W'(m);
    e.dah = bits;
    return e;
  endfunction

  // Character lookup table.
  function automatic entry_t morse_lookup(input logic [CODE_W-1:0] code);
    entry_t e;
    e = mk_entry(0, '0);
    case (code)
      "a":  e = mk_entry(2, 7'b0100000);
      "b":  e = mk_entry(4, 7'b1000000);
      "c":  e = mk_entry(4, 7'b1010000);
      "d":  e = mk_entry(3, 7'b1000000);
      "e":  e = mk_entry(1, 7'b0000000);
      "f":  e = mk_entry(4, 7'b0010000);
      "g":  e = mk_entry(3, 7'b1100000);
      "h":  e = mk_entry(4, 7'b0000000);
      "i":  e = mk_entry(2, 7'b0000000);
      "j":  e = mk_entry(4, 7'b0111000);
      "k":  e = mk_entry(3, 7'b1010000);
      "l":  e = mk_entry(4, 7'b0100000);
      "m":  e = mk_entry(2, 7'b1100000);
      "n":  e = mk_entry(2, 7'b1000000);
      "o":  e = mk_entry(3, 7'b1110000);
      "p":  e = mk_entry(4, 7'b0110000);
      "q":  e = mk_entry(4, 7'b1101000);
      "r":  e = mk_entry(3, 7'b0100000);
      "s":  e = mk_entry(3, 7'b0000000);
      "t":  e = mk_entry(1, 7'b1000000);
      "u":  e = mk_entry(3, 7'b0010000);
      "v":  e = mk_entry(4, 7'b0001000);
      "w":  e = mk_entry(3, 7'b0110000);
      "x":  e = mk_entry(4, 7'b1001000);
      "y":  e = mk_entry(4, 7'b1011000);
      "z":  e = mk_entry(4, 7'b1100000);
      " ":  e = mk_entry(1, 7'b0000000);
      "1":  e = mk_entry(5, 7'b0111100);
      "2":  e = mk_entry(5, 7'b0011100);
      "3":  e = mk_entry(5, 7'b0001100);
      "4":  e = mk_entry(5, 7'b0000100);
      "5":  e = mk_entry(5, 7'b0000000);
      "6":  e = mk_entry(5, 7'b1000000);
      "7":  e = mk_entry(5, 7'b1100000);
      "8":  e = mk_entry(5, 7'b1110000);
      "9":  e = mk_entry(5, 7'b1111000);
      "0":  e = mk_entry(5, 7'b1111100);
      ".":  e = mk_entry(6, 7'b0101010);
      ",":  e = mk_entry(6, 7'b1100110);
      "?":  e = mk_entry(6, 7'b0011000);
      "'":  e = mk_entry(6, 7'b0111100);
      "!":  e = mk_entry(6, 7'b1010110);
      "/":  e = mk_entry(5, 7'b1001000);
      "(":  e = mk_entry(5, 7'b1011000);
      ")":  e = mk_entry(6, 7'b1011010);
      "&":  e = mk_entry(5, 7'b0100000);
      ":":  e = mk_entry(6, 7'b1110000);
      ";":  e = mk_entry(6, 7'b1010100);
      "=":  e = mk_entry(5, 7'b1000100);
      "+":  e = mk_entry(5, 7'b0101000);
      "-":  e = mk_entry(6, 7'b1000010);
      "_":  e = mk_entry(6, 7'b0011010);
      "\"": e = mk_entry(6, 7'b0100100);
      "$":  e = mk_entry(7, 7'b0001001);
      "@":  e = mk_entry(6, 7'b0110100);
      default: e = mk_entry(0, '0);
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/morse_char_to_pulses_top.sv */
// Morse character encoder: pattern ROM, interval sequencer and output register.
//
// Usage:
//   Input channel: char_code_i with in_valid_i / in_stall_o. A word is taken
//   at a clock edge where in_valid_i is high and in_stall_o is low.
//   Output channel: led_on_o, duration_ticks_o, last_o with out_valid_o /
//   out_stall_i. Each word is one interval: on, then off, for every symbol;
//   last_o marks the final off interval of a character.
//   Config channel: cfg_unit_ticks_i with cfg_valid_i / cfg_ready_o sets the
//   unit length in ticks (0 acts as 1). Write it only while idle.
// Path: a taken character is read from the pattern ROM at the accepting edge;
//   the sequencer then loads from the ROM register, and the output register
//   loads from the sequencer once no stalled word is held there.
// Throughput: the sequencer issues one interval per cycle while the receiver
//   does not stall; an unmapped character yields no words.
// Reset: the unit length returns to 300 ticks and the block is idle.
// Stall: while out_stall_i is high with a valid word, the output register holds
//   it and the sequencer waits; a new character is taken only after the last
//   interval of the previous one has entered the output register.
`default_nettype none

module morse_char_to_pulses_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [mcp_pkg::CODE_W-1:0] char_code_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            led_on_o,
  output logic [mcp_pkg::DUR_W-1:0]       duration_ticks_o,
  output logic                            last_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [mcp_pkg::UNIT_W-1:0] cfg_unit_ticks_i
);

  import mcp_pkg::*;

  `include "morse_char_to_pulses_top_defines.svh"

  state_e             state_q, state_d;
  entry_t             rom_q;
  logic [UNIT_W-1:0]  unit_q;
  logic [DUR_W-1:0]   dah_q;
  logic [PAT_W-1:0]   sym_q, sym_d;
  logic [LEN_W-1:0]   left_q, left_d;
  logic               off_q, off_d;
  logic               out_valid_q, out_valid_d;
  logic               led_q, led_d;
  logic [DUR_W-1:0]   dur_q, dur_d;
  logic               last_q, last_d;
  logic               in_acc;
  logic               advance;
  logic [UNIT_W-1:0]  cfg_unit;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign advance     = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_unit    = (cfg_unit_ticks_i == '0) ? UNIT_W'(1) : cfg_unit_ticks_i;

  // Hold unit length and the matching dah length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q <= UNIT_RESET;
      dah_q  <= DUR_W'(UNIT_RESET) + {1'b0, UNIT_RESET, 1'b0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unit_q <= cfg_unit;
      dah_q  <= DUR_W'(cfg_unit) + {1'b0, cfg_unit, 1'b0};
    end
  end

  // Read the pattern ROM on each accepted character.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rom_q <= morse_lookup(char_code_i);
    end
  end

  // Sequencer and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      left_q      <= '0;
      off_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      left_q      <= left_d;
      off_q       <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    led_q <= led_d;
    dur_q <= dur_d;
    last_q <= last_d;
  end

  // Next state and next interval.
  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    left_d      = left_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && out_stall_i;
    led_d       = led_q;
    dur_d       = dur_q;
    last_d      = last_q;
    in_stall_o  = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // Drop unmapped characters, else load the symbol shifter.
        if (rom_q.len == '0) begin
          state_d = ST_IDLE;
        end else begin
          sym_d   = rom_q.dah;
          left_d  = rom_q.len;
          off_d   = 1'b0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (advance) begin
          out_valid_d = 1'b1;
          if (!off_q) begin
            led_d  = 1'b1;
            dur_d  = sym_q[PAT_W-1] ? dah_q : DUR_W'(unit_q);
            last_d = 1'b0;
            off_d  = 1'b1;
          end else begin
            led_d  = 1'b0;
            dur_d  = DUR_W'(unit_q);
            last_d = (left_q == LEN_W'(1));
            off_d  = 1'b0;
            sym_d  = {sym_q[PAT_W-2:0], 1'b0};
            left_d = left_q - LEN_W'(1);
            if (left_q == LEN_W'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign led_on_o         = led_q;
  assign duration_ticks_o = dur_q;
  assign last_o           = last_q;

  `MCP_ASSERT_IMPLY(a_emit_left, clk_i, rst_ni, state_q == ST_EMIT, left_q != '0, "empty emit")
  `MCP_ASSERT_NEXT(a_acc_lookup, clk_i, rst_ni, in_acc, state_q == ST_LOOKUP, "no lookup")
  `MCP_ASSERT_IMPLY(a_last_off, clk_i, rst_ni, out_valid_o && last_o, !led_on_o, "last is on")
  `MCP_ASSERT_IMPLY(a_dur_nz, clk_i, rst_ni, out_valid_o, duration_ticks_o != '0, "zero length")

endmodule

`default_nettype wire

/* sim/morse_char_to_pulses_top_tb.sv */
// Testbench for the Morse character encoder: predicted intervals checked against the DUT.
`default_nettype none

module morse_char_to_pulses_top_tb;

  import mcp_pkg::*;

  localparam int unsigned UNIT_AT_RESET = 300;
  localparam int unsigned DAH_UNITS     = 3;
  localparam byte         DAH_MARK      = "-";
  localparam int          MAX_REPORTS   = 10;
  localparam int          DRAIN_CYCLES  = 12;
  localparam string       MAPPED_CHARS  =
    "abcdefghijklmnopqrstuvwxyz 1234567890.,?'!/()&:;=+-_\"$@";

  // One expected output word: an on or off interval.
  typedef struct {
    logic [CODE_W-1:0] char_code;
    logic              led_on;
    logic [DUR_W-1:0]  dur;
    logic              last;
  } interval_t;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [CODE_W-1:0] char_code_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              led_on_o;
  logic [DUR_W-1:0]  duration_ticks_o;
  logic              last_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [UNIT_W-1:0] cfg_unit_ticks_i;

  interval_t         pending_intervals[$];
  logic [UNIT_W-1:0] unit_ticks_cfg;
  bit                idle_in;
  bit                idle_out;
  int                mismatch_cnt;
  int                chars_sent;
  int                unmapped_sent;
  int                intervals_seen;
  int                unit_writes;

  morse_char_to_pulses_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .char_code_i      (char_code_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .led_on_o         (led_on_o),
    .duration_ticks_o (duration_ticks_o),
    .last_o           (last_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_unit_ticks_i (cfg_unit_ticks_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #3000000;
    $display("timeout: %0d intervals still expected", pending_intervals.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Morse pattern of a character; empty when the character is not mapped.
  function automatic string morse_pattern(input logic [CODE_W-1:0] c);
    case (c)
      "a": return ".-";      "b": return "-...";    "c": return "-.-.";
      "d": return "-..";     "e": return ".";       "f": return "..-.";
      "g": return "--.";     "h": return "....";    "i": return "..";
      "j": return ".---";    "k": return "-.-";     "l": return ".-..";
      "m": return "--";      "n": return "-.";      "o": return "---";
      "p": return ".--.";    "q": return "--.-";    "r": return ".-.";
      "s": return "...";     "t": return "-";       "u": return "..-";
      "v": return "...-";    "w": return ".--";     "x": return "-..-";
      "y": return "-.--";    "z": return "--..";    " ": return ".";
      "1": return ".----";   "2": return "..---";   "3": return "...--";
      "4": return "....-";   "5": return ".....";   "6": return "-....";
      "7": return "--...";   "8": return "---..";   "9": return "----.";
      "0": return "-----";
      ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
      "'": return ".----.";  "!": return "-.-.--";  "/": return "-..-.";
      "(": return "-.--.";   ")": return "-.--.-";  "&": return ".-...";
      ":": return "---...";  ";": return "-.-.-.";  "=": return "-...-";
      "+": return ".-.-.";   "-": return "-....-";  "_": return "..--.-";
      "\"": return ".-..-."; "$": return "...-..-"; "@": return ".--.-.";
      default: return "";
    endcase
  endfunction

  // Queue the on/off intervals a character should produce at the current unit length.
  task automatic queue_char_intervals(input logic [CODE_W-1:0] c);
    string            pat;
    int               nsym;
    logic [DUR_W-1:0] unit;
    interval_t        iv;
    pat  = morse_pattern(c);
    nsym = (pat.len() > MAX_SYMBOLS) ? MAX_SYMBOLS : pat.len();
    unit = (unit_ticks_cfg == '0) ? DUR_W'(1) : DUR_W'(unit_ticks_cfg);
    if (nsym == 0) unmapped_sent++;
    iv.char_code = c;
    for (int s = 0; s < nsym; s++) begin
      iv.led_on = 1'b1;
      iv.dur    = (pat[s] == DAH_MARK) ? unit * DUR_W'(DAH_UNITS) : unit;
      iv.last   = 1'b0;
      pending_intervals.push_back(iv);
      iv.led_on = 1'b0;
      iv.dur    = unit;
      iv.last   = (s == nsym - 1);
      pending_intervals.push_back(iv);
    end
  endtask

  // Send one character, with an optional idle burst ahead of it.
  task automatic send_char(input logic [CODE_W-1:0] c);
    if (idle_in && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (in_stall_o);
    queue_char_intervals(c);
    chars_sent++;
  endtask

  // Drop valid and wait until every expected interval is out and the block is quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_intervals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write the unit length; call only while drained.
  task automatic set_unit_ticks(input logic [UNIT_W-1:0] v);
    cfg_valid_i      <= 1'b1;
    cfg_unit_ticks_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i    <= 1'b0;
    unit_ticks_cfg  = v;
    unit_writes++;
  endtask

  function automatic logic [CODE_W-1:0] random_char();
    string txt;
    txt = MAPPED_CHARS;
    if ($urandom_range(0, 4) == 0) return CODE_W'($urandom_range(0, 255));
    return txt[$urandom_range(0, txt.len() - 1)];
  endfunction

  // Output stall generator: random bursts of out_stall_i while idle_out is set.
  initial begin
    int hold_cnt;
    hold_cnt    = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
      end else if (idle_out && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        hold_cnt     = $urandom_range(0, 4);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted output word against the oldest expected interval.
  always @(posedge clk_i) begin
    interval_t iv;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      intervals_seen++;
      if (pending_intervals.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display("unexpected interval: on=%0d dur=%0d last=%0d",
                   led_on_o, duration_ticks_o, last_o);
      end else begin
        iv = pending_intervals.pop_front();
        if (led_on_o !== iv.led_on || duration_ticks_o !== iv.dur || last_o !== iv.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("char 0x%02h: exp on=%0d dur=%0d last=%0d, got on=%0d dur=%0d last=%0d",
                     iv.char_code, iv.led_on, iv.dur, iv.last,
                     led_on_o, duration_ticks_o, last_o);
        end
      end
    end
  end

  // Directed characters at the reset unit length: dit-only, dah-only, longest,
  // unmapped codes and the field extremes.
  task automatic test_directed_chars();
    logic [CODE_W-1:0] chars[12];
    chars = '{"e", "t", " ", "5", "0", "$", ".", "@", "A", 8'h00, 8'hFF, "a"};
    idle_in  = 1'b0;
    idle_out = 1'b0;
    foreach (chars[i]) send_char(chars[i]);
    wait_drained();
  endtask

  // Unit length extremes: zero acts as one, one, and the largest value.
  task automatic test_unit_extremes();
    logic [UNIT_W-1:0] units[3];
    units = '{16'd0, 16'd1, 16'hFFFF};
    idle_in  = 1'b1;
    idle_out = 1'b1;
    foreach (units[i]) begin
      set_unit_ticks(units[i]);
      send_char("$");
      send_char("0");
      send_char("q");
      wait_drained();
    end
  endtask

  // Random text over several unit lengths, idling switched on and off per stretch.
  task automatic test_random_text();
    logic [UNIT_W-1:0] units[4];
    units = '{UNIT_W'($urandom_range(1, 20)), UNIT_W'($urandom_range(0, 65535)),
              16'hFFFF, 16'd1};
    foreach (units[i]) begin
      set_unit_ticks(units[i]);
      for (int k = 0; k < 20; k++) begin
        if (k % 8 == 0) begin
          idle_in  = $urandom_range(0, 2) != 0;
          idle_out = $urandom_range(0, 2) != 0;
        end
        send_char(random_char());
      end
      wait_drained();
    end
  endtask

  // Back-to-back characters with no idling on either side.
  task automatic test_tail_no_idle();
    idle_in  = 1'b0;
    idle_out = 1'b0;
    set_unit_ticks(UNIT_W'(UNIT_AT_RESET));
    repeat (20) send_char(random_char());
    wait_drained();
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    char_code_i      = '0;
    cfg_valid_i      = 1'b0;
    cfg_unit_ticks_i = '0;
    unit_ticks_cfg   = UNIT_W'(UNIT_AT_RESET);
    idle_in          = 1'b0;
    idle_out         = 1'b0;
    mismatch_cnt     = 0;
    chars_sent       = 0;
    unmapped_sent    = 0;
    intervals_seen   = 0;
    unit_writes      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_chars();
    test_unit_extremes();
    test_random_text();
    test_tail_no_idle();

    $display("covered %0d characters (%0d unmapped), %0d intervals checked",
             chars_sent, unmapped_sent, intervals_seen);
    $display("unit length written %0d times, including 0, 1 and 65535", unit_writes);
    if (mismatch_cnt == 0 && pending_intervals.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
